// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked only while out of reset
`define ASSERT_AR(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_AR(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/core/cds_pkg.sv =====
// ----------------------------------------------------------------------------
// cds_pkg
// Types, codes and calendar helpers shared by the date stepper.
// ----------------------------------------------------------------------------
package cds_pkg;

  typedef enum logic [3:0] {
    CMD_DAY_BACK   = 4'd0,
    CMD_DAY_FWD    = 4'd1,
    CMD_WEEK_UP    = 4'd2,
    CMD_WEEK_DOWN  = 4'd3,
    CMD_MONTH_FWD  = 4'd4,
    CMD_MONTH_BACK = 4'd5,
    CMD_YEAR_FWD   = 4'd6,
    CMD_YEAR_BACK  = 4'd7,
    CMD_LOAD       = 4'd8,
    CMD_CONFIRM    = 4'd9,
    CMD_CANCEL     = 4'd10
  } cmd_e;

  typedef enum logic [1:0] {
    FIN_NONE    = 2'd0,
    FIN_CONFIRM = 2'd1,
    FIN_CANCEL  = 2'd2
  } finish_e;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  typedef struct packed {
    date_t   date;
    logic    month_changed;
    finish_e finish;
  } step_res_t;

  localparam logic [15:0] RESET_YEAR      = 16'd2000;
  localparam logic [3:0]  RESET_MONTH     = 4'd1;
  localparam logic [4:0]  RESET_DAY       = 5'd1;
  localparam logic [3:0]  MONTHS_PER_YEAR = 4'd12;
  localparam logic [4:0]  DAYS_PER_WEEK   = 5'd7;
  localparam logic [3:0]  MONTH_FEB       = 4'd2;
  localparam logic [3:0]  MONTH_APR       = 4'd4;
  localparam logic [3:0]  MONTH_JUN       = 4'd6;
  localparam logic [3:0]  MONTH_SEP       = 4'd9;
  localparam logic [3:0]  MONTH_NOV       = 4'd11;
  localparam logic [4:0]  LEN_LONG        = 5'd31;
  localparam logic [4:0]  LEN_SHORT       = 5'd30;
  localparam logic [4:0]  LEN_FEB_LEAP    = 5'd29;
  localparam logic [4:0]  LEN_FEB         = 5'd28;

  // y % 25 == 0  <=>  (y * inv(25) mod 2^16) <= floor(65535 / 25)
  localparam logic [15:0] INV25           = 16'd23593;
  localparam logic [15:0] MAX_Q25         = 16'd2621;

  function automatic logic is_leap(input logic [15:0] y);
    logic [15:0] p;
    logic        div25;
    p     = y * INV25;
    div25 = (p <= MAX_Q25);
    // given y % 4 == 0: y % 100 == 0 <=> div25, y % 400 == 0 <=> div25 and y % 16 == 0
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [4:0] month_len(input logic [15:0] y, input logic [3:0] m);
    logic [4:0] len;
    unique case (m)
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_SHORT;
      MONTH_FEB: len = is_leap(y) ? LEN_FEB_LEAP : LEN_FEB;
      default:   len = LEN_LONG;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/core/cds_step.sv =====
// ----------------------------------------------------------------------------
// cds_step
// Next-date logic: applies one navigation command to the current date.
// ----------------------------------------------------------------------------
module cds_step
  import cds_pkg::*;
(
  input  logic [3:0]  cmd_i,
  input  logic [15:0] load_year_i,
  input  logic [3:0]  load_month_i,
  input  logic [4:0]  load_day_i,
  input  date_t       cur_i,
  output step_res_t   res_o
);

  logic [4:0]  last_cur;
  logic [4:0]  last_new;
  logic [15:0] ny;
  logic [3:0]  nm;
  logic [4:0]  nd;
  logic        take_len;
  logic        clamp;
  finish_e     fin;
  logic [4:0]  day_fin;

  assign last_cur = month_len(cur_i.year, cur_i.month);

  always_comb begin
    ny       = cur_i.year;
    nm       = cur_i.month;
    nd       = cur_i.day;
    take_len = 1'b0;
    clamp    = 1'b0;
    fin      = FIN_NONE;
    unique case (cmd_i)
      CMD_DAY_BACK: begin
        if (cur_i.day > 5'd1) begin
          nd = cur_i.day - 5'd1;
        end else begin
          take_len = 1'b1;
          if (cur_i.month > 4'd1) begin
            nm = cur_i.month - 4'd1;
          end else begin
            nm = MONTHS_PER_YEAR;
            ny = cur_i.year - 16'd1;
          end
        end
      end
      CMD_DAY_FWD: begin
        if (cur_i.day < last_cur) begin
          nd = cur_i.day + 5'd1;
        end else begin
          nd = 5'd1;
          if (cur_i.month < MONTHS_PER_YEAR) begin
            nm = cur_i.month + 4'd1;
          end else begin
            nm = 4'd1;
            ny = cur_i.year + 16'd1;
          end
        end
      end
      CMD_WEEK_UP: begin
        if (cur_i.day > DAYS_PER_WEEK) begin
          nd = cur_i.day - DAYS_PER_WEEK;
        end else if (({1'b0, cur_i.day} + 6'd28) <= {1'b0, last_cur}) begin
          nd = cur_i.day + 5'd28;
        end else begin
          nd = cur_i.day + 5'd21;
        end
      end
      CMD_WEEK_DOWN: begin
        if (({1'b0, cur_i.day} + {1'b0, DAYS_PER_WEEK}) <= {1'b0, last_cur}) begin
          nd = cur_i.day + DAYS_PER_WEEK;
        end else begin
          priority if (cur_i.day > 5'd28) begin
            nd = cur_i.day - 5'd28;
          end else if (cur_i.day > 5'd21) begin
            nd = cur_i.day - 5'd21;
          end else if (cur_i.day > 5'd14) begin
            nd = cur_i.day - 5'd14;
          end else if (cur_i.day > DAYS_PER_WEEK) begin
            nd = cur_i.day - DAYS_PER_WEEK;
          end else begin
            nd = cur_i.day;
          end
        end
      end
      CMD_MONTH_FWD: begin
        clamp = 1'b1;
        if (cur_i.month < MONTHS_PER_YEAR) begin
          nm = cur_i.month + 4'd1;
        end else begin
          nm = 4'd1;
          ny = cur_i.year + 16'd1;
        end
      end
      CMD_MONTH_BACK: begin
        clamp = 1'b1;
        if (cur_i.month > 4'd1) begin
          nm = cur_i.month - 4'd1;
        end else begin
          nm = MONTHS_PER_YEAR;
          ny = cur_i.year - 16'd1;
        end
      end
      CMD_YEAR_FWD: begin
        clamp = 1'b1;
        ny    = cur_i.year + 16'd1;
      end
      CMD_YEAR_BACK: begin
        clamp = 1'b1;
        ny    = cur_i.year - 16'd1;
      end
      CMD_LOAD: begin
        clamp = 1'b1;
        ny    = load_year_i;
        if (load_month_i == 4'd0) begin
          nm = 4'd1;
        end else if (load_month_i > MONTHS_PER_YEAR) begin
          nm = MONTHS_PER_YEAR;
        end else begin
          nm = load_month_i;
        end
        nd = (load_day_i == 5'd0) ? 5'd1 : load_day_i;
      end
      CMD_CONFIRM: fin = FIN_CONFIRM;
      CMD_CANCEL:  fin = FIN_CANCEL;
      default: ;
    endcase
  end

  assign last_new = month_len(ny, nm);

  always_comb begin
    if (take_len || (clamp && (nd > last_new))) begin
      day_fin = last_new;
    end else begin
      day_fin = nd;
    end
  end

  assign res_o.date.year     = ny;
  assign res_o.date.month    = nm;
  assign res_o.date.day      = day_fin;
  assign res_o.month_changed = (ny != cur_i.year) || (nm != cur_i.month);
  assign res_o.finish        = fin;

endmodule

// ===== rtl/core/calendar_date_stepper.sv =====
// ----------------------------------------------------------------------------
// calendar_date_stepper
// Keeps a selected Gregorian date and applies one navigation command per beat.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries a command and load fields;
// output channel (out_valid_o / out_stall_i) returns one beat per command with
// the date after the step, a month-changed flag and the finish code.
// An accepted beat lands in the input register; once the output register can
// advance, the step logic runs against the stored date and writes the date and
// result registers together, and the result register drives the output channel.
// Throughput: one command per cycle while the receiver does not stall; the
// stored date is updated in that same register stage, so back-to-back commands
// see each other's effect.
// Critical path: next year/month select, leap test multiply, day clamp.
// Reset clears both stages and sets the date to 2000-01-01.
// While the receiver stalls, the result holds; one more beat is still taken
// into the input register, after which in_stall_o is raised.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module calendar_date_stepper
  import cds_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  command_i,
  input  logic [15:0] load_year_i,
  input  logic [3:0]  load_month_i,
  input  logic [4:0]  load_day_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o,
  output logic        month_changed_o,
  output logic [1:0]  finish_o
);

  logic        s1_valid_q;
  logic [3:0]  cmd_q;
  logic [15:0] ld_year_q;
  logic [3:0]  ld_month_q;
  logic [4:0]  ld_day_q;
  date_t       date_q;
  logic        out_valid_q;
  step_res_t   res_q;
  step_res_t   step_res;
  logic        advance;
  logic        in_fire;
  logic        s1_fire;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign s1_fire    = s1_valid_q && advance;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q      <= command_i;
      ld_year_q  <= load_year_i;
      ld_month_q <= load_month_i;
      ld_day_q   <= load_day_i;
    end
  end

  cds_step u_step (
    .cmd_i        (cmd_q),
    .load_year_i  (ld_year_q),
    .load_month_i (ld_month_q),
    .load_day_i   (ld_day_q),
    .cur_i        (date_q),
    .res_o        (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      date_q.year  <= RESET_YEAR;
      date_q.month <= RESET_MONTH;
      date_q.day   <= RESET_DAY;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
        date_q      <= step_res.date;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign year_o          = res_q.date.year;
  assign month_o         = res_q.date.month;
  assign day_o           = res_q.date.day;
  assign month_changed_o = res_q.month_changed;
  assign finish_o        = res_q.finish;

  `ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> (!out_valid_q && !s1_valid_q), "pipeline not empty in reset")
  `ASSERT_AR(a_date_legal, clk_i, rst_ni, (date_q.month >= 4'd1) && (date_q.month <= MONTHS_PER_YEAR) && (date_q.day >= 5'd1) && (date_q.day <= month_len(date_q.year, date_q.month)), "stored date out of range")
  `ASSERT_AR(a_out_mirrors_date, clk_i, rst_ni, out_valid_q |-> (res_q.date == date_q), "pending result differs from stored date")
  `ASSERT_AR(a_date_hold, clk_i, rst_ni, !s1_fire |=> $stable(date_q), "date moved without a step")
  `ASSERT_AR(a_finish_no_move, clk_i, rst_ni, (out_valid_q && (res_q.finish != FIN_NONE)) |-> !res_q.month_changed, "finish beat reports a month change")

endmodule
